// ----- design/todc_pkg.sv -----
// ----------------------------------------------------------------------------
// todc_pkg: shared types and constants of the time-of-day display clock
// Register indexes, display addresses, digit split and brightness lookup.
// ----------------------------------------------------------------------------
package todc_pkg;

    // Configuration port
    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 16;

    localparam logic [CfgIndexW-1:0] REG_TICK_PERIOD  = 2'd0;
    localparam logic [CfgIndexW-1:0] REG_START_HOUR   = 2'd1;
    localparam logic [CfgIndexW-1:0] REG_START_MINUTE = 2'd2;
    localparam logic [CfgIndexW-1:0] REG_START_SECOND = 2'd3;

    localparam logic [15:0] TICK_PERIOD_RST = 16'd15635;

    // Display run: six digit writes then one brightness write
    localparam int DIGIT_COUNT = 6;
    localparam int IdxW        = $clog2(DIGIT_COUNT + 1);

    localparam logic [3:0] BRIGHT_ADDR = 4'hA;

    localparam logic [5:0] SEC_MAX  = 6'd59;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [4:0] HOUR_MAX = 5'd23;

    typedef logic [3:0] t_nibble;

    // Second boundary event handed from the time keeper to the output stage
    typedef struct packed {
        logic                            elapsed;
        logic [DIGIT_COUNT-1:0][3:0]     digit;
        t_nibble                         bright;
        logic                            heartbeat;
    } t_time_evt;

    // Split a value below 60 into tens and ones digits, {tens, ones}
    function automatic logic [7:0] split_bcd(input logic [5:0] v);
        logic [3:0] tens;
        logic [5:0] rem;
        begin
            if (v >= 6'd50) begin
                tens = 4'd5;
                rem  = v - 6'd50;
            end else if (v >= 6'd40) begin
                tens = 4'd4;
                rem  = v - 6'd40;
            end else if (v >= 6'd30) begin
                tens = 4'd3;
                rem  = v - 6'd30;
            end else if (v >= 6'd20) begin
                tens = 4'd2;
                rem  = v - 6'd20;
            end else if (v >= 6'd10) begin
                tens = 4'd1;
                rem  = v - 6'd10;
            end else begin
                tens = 4'd0;
                rem  = v;
            end
            split_bcd = {tens, rem[3:0]};
        end
    endfunction

    // Display brightness for each hour of the day
    function automatic t_nibble bright_lut(input logic [4:0] hour);
        t_nibble b;
        begin
            case (hour)
                5'd0, 5'd1, 5'd2, 5'd3: b = 4'h5;
                5'd4:                   b = 4'h6;
                5'd5:                   b = 4'h7;
                5'd6:                   b = 4'h8;
                5'd7:                   b = 4'h9;
                5'd8:                   b = 4'hB;
                5'd9:                   b = 4'hD;
                5'd10, 5'd11:           b = 4'hE;
                5'd12, 5'd13, 5'd14:    b = 4'hF;
                5'd15, 5'd16, 5'd17:    b = 4'hE;
                5'd18:                  b = 4'hD;
                5'd19:                  b = 4'hC;
                5'd20:                  b = 4'hB;
                5'd21:                  b = 4'h9;
                5'd22:                  b = 4'h8;
                5'd23:                  b = 4'h6;
                default:                b = 4'h5;
            endcase
            bright_lut = b;
        end
    endfunction

endpackage

// ----- design/todc_time.sv -----
// ----------------------------------------------------------------------------
// todc_time: tick prescaler and 24-hour time keeper
// Counts ticks, advances hh:mm:ss on each period overflow and toggles the
// heartbeat. Emits the new time as digits on the tick that ends a second.
// ----------------------------------------------------------------------------
module todc_time (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic                            i_cfg_we,
    input  logic [todc_pkg::CfgIndexW-1:0]  i_cfg_index,
    input  logic [todc_pkg::CfgDataW-1:0]   i_cfg_data,
    output logic                            o_quiet,
    output todc_pkg::t_time_evt             o_evt
);
    import todc_pkg::*;

    logic [15:0] r_period, n_period;
    logic [15:0] r_cnt,    n_cnt;
    logic [5:0]  r_sec,    n_sec;
    logic [5:0]  r_min,    n_min;
    logic [4:0]  r_hour,   n_hour;
    logic        r_hb,     n_hb;

    logic        elapsed;
    logic [5:0]  sec_inc, min_inc;
    logic [4:0]  hour_inc;
    logic [7:0]  bcd_h, bcd_m, bcd_s;

    // next tick cannot end a second
    assign o_quiet = (r_cnt < r_period);
    assign elapsed = i_step && !o_quiet;

    // clock advance with carries
    always_comb begin
        sec_inc  = r_sec;
        min_inc  = r_min;
        hour_inc = r_hour;
        if (r_sec == SEC_MAX) begin
            sec_inc = 6'd0;
            if (r_min == MIN_MAX) begin
                min_inc  = 6'd0;
                hour_inc = (r_hour == HOUR_MAX) ? 5'd0 : r_hour + 5'd1;
            end else begin
                min_inc = r_min + 6'd1;
            end
        end else begin
            sec_inc = r_sec + 6'd1;
        end
    end

    // next state: ticks and configuration writes
    always_comb begin
        n_period = r_period;
        n_cnt    = r_cnt;
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_hb     = r_hb;
        if (i_step) begin
            if (elapsed) begin
                n_cnt  = 16'd0;
                n_sec  = sec_inc;
                n_min  = min_inc;
                n_hour = hour_inc;
                n_hb   = !r_hb;
            end else begin
                n_cnt = r_cnt + 16'd1;
            end
        end
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TICK_PERIOD:  n_period = i_cfg_data;
                REG_START_HOUR:   n_hour = (i_cfg_data[4:0] <= HOUR_MAX) ?
                                           i_cfg_data[4:0] : 5'd0;
                REG_START_MINUTE: n_min  = (i_cfg_data[5:0] <= MIN_MAX) ?
                                           i_cfg_data[5:0] : 6'd0;
                REG_START_SECOND: n_sec  = (i_cfg_data[5:0] <= SEC_MAX) ?
                                           i_cfg_data[5:0] : 6'd0;
                default:          n_period = r_period;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= TICK_PERIOD_RST;
            r_cnt    <= 16'd0;
            r_sec    <= 6'd0;
            r_min    <= 6'd0;
            r_hour   <= 5'd0;
            r_hb     <= 1'b1;
        end else begin
            r_period <= n_period;
            r_cnt    <= n_cnt;
            r_sec    <= n_sec;
            r_min    <= n_min;
            r_hour   <= n_hour;
            r_hb     <= n_hb;
        end
    end

    // digits of the advanced time, hours first, tens digit first
    assign bcd_h = split_bcd({1'b0, hour_inc});
    assign bcd_m = split_bcd(min_inc);
    assign bcd_s = split_bcd(sec_inc);

    always_comb begin
        o_evt.elapsed   = elapsed;
        o_evt.digit[0]  = bcd_h[7:4];
        o_evt.digit[1]  = bcd_h[3:0];
        o_evt.digit[2]  = bcd_m[7:4];
        o_evt.digit[3]  = bcd_m[3:0];
        o_evt.digit[4]  = bcd_s[7:4];
        o_evt.digit[5]  = bcd_s[3:0];
        o_evt.bright    = bright_lut(hour_inc);
        o_evt.heartbeat = !r_hb;
    end

endmodule

// ----- design/time_of_day_display_clock.sv -----
// ----------------------------------------------------------------------------
// time_of_day_display_clock: 24-hour clock driving a digit display
// Prescales ticks into seconds and writes hh:mm:ss plus brightness.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_tick) carries timer ticks; a
//   transaction with i_tick low has no effect. Every tick_period+1 ticks the
//   clock advances one second and a run of seven display writes goes out on
//   the output channel (o_out_valid / i_out_ready): addresses 1 to 6 with the
//   digits hh mm ss, tens first, then address 10 with the brightness, marked
//   by o_last. o_heartbeat carries the level after this second's toggle.
//   The first write is valid in the cycle after the second-ending tick.
//   Throughput: one tick per cycle. The output register holds one run; while
//   it drains, ticks that cannot end a second are still taken, and the tick
//   that would end one waits until the brightness write has been taken.
//   Stalls on the output hold the current write unchanged.
//   Reset: period counter and time 00:00:00, heartbeat high, tick period
//   15635, no run pending. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module time_of_day_display_clock (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // tick channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_tick,
    // display write channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [3:0]                      o_reg_address,
    output logic [3:0]                      o_reg_data,
    output logic                            o_heartbeat,
    output logic                            o_last,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [todc_pkg::CfgIndexW-1:0]  i_cfg_index,
    input  logic [todc_pkg::CfgDataW-1:0]   i_cfg_data
);
    import todc_pkg::*;

    logic                        quiet;
    logic                        in_take;
    logic                        out_take;
    t_time_evt                   evt;

    logic                        r_active, n_active;
    logic [IdxW-1:0]             r_idx,    n_idx;
    logic [DIGIT_COUNT-1:0][3:0] r_digit;
    t_nibble                     r_bright;
    logic                        r_hb;

    assign o_in_ready = !r_active || quiet;
    assign in_take    = i_in_valid && o_in_ready;
    assign out_take   = o_out_valid && i_out_ready;

    todc_time u_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_take && i_tick),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_quiet     (quiet),
        .o_evt       (evt)
    );

    // run sequencer: load on a second boundary, step on each taken write
    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        if (evt.elapsed) begin
            n_active = 1'b1;
            n_idx    = '0;
        end else if (out_take) begin
            if (o_last) begin
                n_active = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
        end
    end

    // snapshot of the run payload
    always_ff @(posedge i_clk) begin
        if (evt.elapsed) begin
            r_digit  <= evt.digit;
            r_bright <= evt.bright;
            r_hb     <= evt.heartbeat;
        end
    end

    // output write selection
    always_comb begin
        o_out_valid = r_active;
        o_last      = (r_idx == IdxW'(DIGIT_COUNT));
        o_heartbeat = r_hb;
        if (o_last) begin
            o_reg_address = BRIGHT_ADDR;
            o_reg_data    = r_bright;
        end else begin
            o_reg_address = 4'(r_idx) + 4'd1;
            o_reg_data    = r_digit[r_idx];
        end
    end

    // a new second never lands on a run still pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !evt.elapsed)
        else $error("second boundary while a display run is pending");

    // the run ends right after the brightness write is taken
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && o_last) |=> !o_out_valid)
        else $error("display run did not end after the last write");

    // the last write always goes to the brightness address
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_reg_address == BRIGHT_ADDR))
        else $error("last write not addressed to brightness");

    // heartbeat holds over a whole run
    a_hb_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && $past(o_out_valid)) |-> $stable(o_heartbeat))
        else $error("heartbeat changed inside a display run");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the time-of-day display clock
// Sends tick transactions and register writes, keeps its own model of the
// 24-hour clock and checks every display write run against it, with random
// idling on both channels, a long output hold-off and directed corner rows.
// ----------------------------------------------------------------------------
module tb;
    import todc_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_TICKS   = 32;
    localparam int QUIET_TICKS   = 100;
    localparam int IDLE_PCT      = 28;
    localparam int DIR_ROWS      = 29;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       hb;
    } t_clock_time;

    typedef struct packed {
        t_row_kind             kind;
        logic [CfgIndexW-1:0]  idx;
        logic [CfgDataW-1:0]   data;
        logic                  tick;
        logic                  chk;
        t_clock_time           t;
    } t_dir_row;

    typedef struct packed {
        logic [3:0] addr;
        logic [3:0] data;
        logic       hb;
        logic       last;
    } t_disp_write;

    localparam t_clock_time NO_T = '{5'd0, 6'd0, 6'd0, 1'b0};

    // Brightness per hour of the day
    localparam logic [3:0] HOUR_BRIGHT [24] = '{
        4'h5, 4'h5, 4'h5, 4'h5, 4'h6, 4'h7, 4'h8, 4'h9,
        4'hB, 4'hD, 4'hE, 4'hE, 4'hF, 4'hF, 4'hF, 4'hE,
        4'hE, 4'hE, 4'hD, 4'hC, 4'hB, 4'h9, 4'h8, 4'h6
    };

    // Directed rows; typed expectations only where the time is obvious
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b0, 1'b0, NO_T},  // tick low
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b0, NO_T},
        // period dropped below the running count: next tick ends the second
        '{ROW_CFG,  REG_TICK_PERIOD,  16'd0,     1'b0, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b1, '{5'd0, 6'd0, 6'd1, 1'b0}},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b0, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b1, '{5'd0, 6'd0, 6'd2, 1'b1}},
        // second carry into minutes
        '{ROW_CFG,  REG_START_SECOND, 16'd59,    1'b0, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b1, '{5'd0, 6'd1, 6'd0, 1'b0}},
        // full day wrap
        '{ROW_CFG,  REG_START_HOUR,   16'd23,    1'b0, 1'b0, NO_T},
        '{ROW_CFG,  REG_START_MINUTE, 16'd59,    1'b0, 1'b0, NO_T},
        '{ROW_CFG,  REG_START_SECOND, 16'd59,    1'b0, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b1, '{5'd0, 6'd0, 6'd0, 1'b1}},
        // out-of-range start values load zero
        '{ROW_CFG,  REG_START_HOUR,   16'd14,    1'b0, 1'b0, NO_T},
        '{ROW_CFG,  REG_START_HOUR,   16'hFFFF,  1'b0, 1'b0, NO_T},
        '{ROW_CFG,  REG_START_MINUTE, 16'hFFFF,  1'b0, 1'b0, NO_T},
        '{ROW_CFG,  REG_START_SECOND, 16'h003C,  1'b0, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b1, '{5'd0, 6'd0, 6'd1, 1'b0}},
        // brightest hour
        '{ROW_CFG,  REG_START_HOUR,   16'd12,    1'b0, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b1, '{5'd12, 6'd0, 6'd2, 1'b1}},
        // longest period, then shortened below the count
        '{ROW_CFG,  REG_TICK_PERIOD,  16'hFFFF,  1'b0, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b0, NO_T},
        '{ROW_CFG,  REG_TICK_PERIOD,  16'd2,     1'b0, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b1, '{5'd12, 6'd0, 6'd3, 1'b0}},
        '{ROW_CFG,  REG_TICK_PERIOD,  16'd1,     1'b0, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b0, NO_T},
        '{ROW_TICK, REG_TICK_PERIOD,  16'd0,     1'b1, 1'b0, NO_T}
    };

    // DUT connections, inputs driven from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_tick      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [3:0]            o_reg_address;
    logic [3:0]            o_reg_data;
    logic                  o_heartbeat;
    logic                  o_last;
    logic                  i_cfg_we    = 1'b0;
    logic [CfgIndexW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0]   i_cfg_data  = '0;

    // Typed expectation travels with the tick payload
    logic                  typed_on    = 1'b0;
    t_clock_time           typed_time  = NO_T;

    // Clock model state
    logic [15:0]           mdl_period  = TICK_PERIOD_RST;
    logic [15:0]           mdl_count   = '0;
    logic [5:0]            mdl_sec     = '0;
    logic [5:0]            mdl_min     = '0;
    logic [4:0]            mdl_hour    = '0;
    logic                  mdl_hb      = 1'b1;

    t_disp_write           display_writes [$];
    int                    mismatch_count = 0;
    int                    quiet_cycles   = 0;
    int                    hold_left      = 0;
    logic                  hold_req       = 1'b0;
    logic                  quiet_mode     = 1'b0;

    time_of_day_display_clock u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_tick        (i_tick),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_reg_address (o_reg_address),
        .o_reg_data    (o_reg_data),
        .o_heartbeat   (o_heartbeat),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Queue the seven writes of one second: hh mm ss digits, then brightness
    function automatic void queue_display_run(input t_clock_time ct);
        int digits [DIGIT_COUNT];
        digits[0] = ct.hour / 10;
        digits[1] = ct.hour % 10;
        digits[2] = ct.minute / 10;
        digits[3] = ct.minute % 10;
        digits[4] = ct.second / 10;
        digits[5] = ct.second % 10;
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            display_writes.push_back('{4'(k + 1), 4'(digits[k]), ct.hb, 1'b0});
        end
        display_writes.push_back('{BRIGHT_ADDR, HOUR_BRIGHT[ct.hour % 24], ct.hb, 1'b1});
    endfunction

    // One accepted tick through the clock model
    function automatic logic advance_clock(input logic tick);
        if (!tick) return 1'b0;
        if (mdl_count < mdl_period) begin
            mdl_count = mdl_count + 16'd1;
            return 1'b0;
        end
        mdl_count = '0;
        mdl_hb    = ~mdl_hb;
        mdl_sec   = mdl_sec + 6'd1;
        if (mdl_sec >= 6'd60) begin
            mdl_sec = '0;
            mdl_min = mdl_min + 6'd1;
        end
        if (mdl_min >= 6'd60) begin
            mdl_min  = '0;
            mdl_hour = mdl_hour + 5'd1;
        end
        if (mdl_hour >= 5'd24) mdl_hour = '0;
        return 1'b1;
    endfunction

    function automatic void apply_config(input logic [CfgIndexW-1:0] idx,
                                         input logic [CfgDataW-1:0] val);
        case (idx)
            REG_TICK_PERIOD:  mdl_period = val;
            REG_START_HOUR:   mdl_hour = (val[4:0] <= HOUR_MAX) ? val[4:0] : 5'd0;
            REG_START_MINUTE: mdl_min  = (val[5:0] <= MIN_MAX) ? val[5:0] : 6'd0;
            REG_START_SECOND: mdl_sec  = (val[5:0] <= SEC_MAX) ? val[5:0] : 6'd0;
            default: ;
        endcase
    endfunction

    // Start value: at the top, beyond it, or anywhere in range; junk above the field
    function automatic logic [CfgDataW-1:0] pick_start(input int top, input int bits);
        int v;
        case ($urandom_range(0, 3))
            0:       v = top;
            1:       v = $urandom_range(top + 1, (1 << bits) - 1);
            default: v = $urandom_range(0, top);
        endcase
        return CfgDataW'(($urandom() & (32'hFFFF << bits)) | v);
    endfunction

    // Offer one tick transaction; returns at the edge it is accepted
    task automatic send_tick(input logic tick, input logic chk, input t_clock_time ct);
        int gap;
        gap = 0;
        while (!quiet_mode && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tick     <= tick;
        typed_on   <= chk;
        typed_time <= ct;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Register write once the block has drained every pending run
    task automatic cfg_write(input logic [CfgIndexW-1:0] idx,
                             input logic [CfgDataW-1:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (display_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        apply_config(idx, val);
    endtask

    // Receiver: random stalls, optional long hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Predict on accepted ticks, check each accepted display write
    always @(posedge i_clk) begin : monitor
        t_disp_write want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (advance_clock(i_tick) && !typed_on)
                    queue_display_run('{mdl_hour, mdl_min, mdl_sec, mdl_hb});
                if (typed_on)
                    queue_display_run(typed_time);
            end
            if (o_out_valid && i_out_ready) begin
                if (display_writes.size() == 0) begin
                    $error("unexpected display write: reg_address %0d reg_data %0d",
                           o_reg_address, o_reg_data);
                    mismatch_count++;
                end else begin
                    want = display_writes.pop_front();
                    if (o_reg_address !== want.addr) begin
                        $error("reg_address: expected %0d, actual %0d", want.addr, o_reg_address);
                        mismatch_count++;
                    end
                    if (o_reg_data !== want.data) begin
                        $error("reg_data: expected %0d, actual %0d", want.data, o_reg_data);
                        mismatch_count++;
                    end
                    if (o_heartbeat !== want.hb) begin
                        $error("heartbeat: expected %0d, actual %0d", want.hb, o_heartbeat);
                        mismatch_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, o_last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int n_ticks;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG)
                cfg_write(dir_rows[r].idx, dir_rows[r].data);
            else
                send_tick(dir_rows[r].tick, dir_rows[r].chk, dir_rows[r].t);
        end

        // Random phases: new period and start time, then a burst of ticks
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph < 3)
                cfg_write(REG_TICK_PERIOD, 16'd0);
            else
                cfg_write(REG_TICK_PERIOD, 16'($urandom_range(0, 5)));
            cfg_write(REG_START_HOUR,   pick_start(int'(HOUR_MAX), 5));
            cfg_write(REG_START_MINUTE, pick_start(int'(MIN_MAX), 6));
            cfg_write(REG_START_SECOND, pick_start(int'(SEC_MAX), 6));
            quiet_mode = (ph == 2);
            // phase 1: receiver holds off while ticks keep coming
            if (ph == 1) hold_req = 1'b1;
            n_ticks = (ph == 2) ? QUIET_TICKS : PHASE_TICKS;
            repeat (n_ticks) send_tick($urandom_range(99) < 85, 1'b0, NO_T);
            quiet_mode = 1'b0;
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (display_writes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/todc_pkg.sv
design/todc_time.sv
design/time_of_day_display_clock.sv
tb/sv/tb.sv
